// ===== sv/cstrd_pkg.sv =====
// Shared constants and types for the statement reader.
// No dependencies; compile before every other file of the block.
`default_nettype none

package cstrd_pkg;

	// Statement length bound and the counter width that follows from it
	localparam int MAX_STMT = 256;
	localparam int CNT_W    = $clog2(MAX_STMT);
	localparam logic [CNT_W-1:0] STMT_LIMIT = CNT_W'(MAX_STMT - 1);

	// Result queue depth
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef logic [2:0] status_t;

	localparam status_t ST_OK      = 3'd0;
	localparam status_t ST_CLEAN   = 3'd1;
	localparam status_t ST_UNEXP   = 3'd2;
	localparam status_t ST_LONG    = 3'd3;
	localparam status_t ST_NL_STR  = 3'd4;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam logic [7:0] CH_SPACE = 8'h20;

	// One queued result: a character or an end beat, optionally preceded by a held space
	typedef struct packed {
		logic        kind;
		logic [7:0]  chr;
		status_t     status;
		logic [31:0] phys;
		logic [31:0] logical;
		logic        space;
	} res_entry_t;

endpackage

`default_nettype wire

// ===== sv/cstrd_in_if.sv =====
// Input channel of the statement reader: one source byte or end-of-file mark per beat.
// Depends on cstrd_pkg.
`default_nettype none

interface cstrd_in_if;
	import cstrd_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_file;

	modport source (output valid, output in_byte, output end_of_file, input ready);
	modport sink   (input valid, input in_byte, input end_of_file, output ready);
endinterface

`default_nettype wire

// ===== sv/cstrd_out_if.sv =====
// Result channel of the statement reader: one character or statement end per beat.
// Depends on cstrd_pkg.
`default_nettype none

interface cstrd_out_if;
	import cstrd_pkg::*;

	logic               valid;
	logic               ready;
	logic               out_kind;
	logic [7:0]         out_char;
	status_t            end_status;
	logic [31:0]        phys_line;
	logic signed [31:0] logical_line;
	logic               out_last;

	modport source (output valid, output out_kind, output out_char, output end_status,
		output phys_line, output logical_line, output out_last, input ready);
	modport sink   (input valid, input out_kind, input out_char, input end_status,
		input phys_line, input logical_line, input out_last, output ready);
endinterface

`default_nettype wire

// ===== sv/config_statement_reader.sv =====
// Statement reader: turns a source byte stream into normalised ';'-terminated statements.
// Depends on cstrd_pkg, cstrd_in_if and cstrd_out_if.
//
// Usage
//   in_ch  : one beat per source byte (in_byte) or end-of-file mark (end_of_file = 1).
//   out_ch : result beats. out_kind 0 carries one statement character in out_char;
//            out_kind 1 closes the statement with end_status and the line counters.
//            out_last marks the final result beat caused by one input beat; an input
//            beat may cause no result, one, or two (a held space, then a character).
//   Order:   an input beat is registered on acceptance and its results are written
//            to a four-entry result queue on the next edge; out_ch shows the queue
//            head directly.
//   Throughput: one input beat per cycle while in_ch.ready is high. An item that releases
//            a held space takes two output beats, so the output side sets the rate then.
//   Stall: when the receiver holds ready low the queue fills; in_ch.ready drops
//            while the queue plus the item in flight leave no free entry, and
//            rises again once the head entry has gone out in full (a held space
//            and the character behind it leave as one entry).
//   Reset: arst_n clears the scanner to normal mode at line start, both line
//            counters to 1, and empties the queue. After an end-of-file beat every
//            further input beat answers with a clean end until the next reset.
`default_nettype none

module config_statement_reader (
	input  logic        clk,
	input  logic        arst_n,
	cstrd_in_if.sink    in_ch,
	cstrd_out_if.source out_ch
);
	import cstrd_pkg::*;

	// Scan modes
	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_STRING = 2'd1;
	localparam logic [1:0] MODE_DIR    = 2'd2;

	// Directive parser phases: the first four match the word "line"
	localparam logic [3:0] PH_P0      = 4'd0;
	localparam logic [3:0] PH_P1      = 4'd1;
	localparam logic [3:0] PH_P2      = 4'd2;
	localparam logic [3:0] PH_P3      = 4'd3;
	localparam logic [3:0] PH_AFTER   = 4'd4;
	localparam logic [3:0] PH_SPACE   = 4'd5;
	localparam logic [3:0] PH_SIGN    = 4'd6;
	localparam logic [3:0] PH_DIGITS  = 4'd7;
	localparam logic [3:0] PH_VALID   = 4'd8;
	localparam logic [3:0] PH_INVALID = 4'd9;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_L      = 8'h6C;
	localparam logic [7:0] CH_I      = 8'h69;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_E      = 8'h65;

	localparam logic [31:0] VAL_CAP   = 32'h8000_0000;
	localparam logic [31:0] LINE_MAX  = 32'h7FFF_FFFF;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// Expected letter of "line" at prefix phases one to three
	function automatic logic [7:0] line_char(input logic [3:0] ph);
		logic [7:0] r;
		case (ph)
			PH_P1:   r = CH_I;
			PH_P2:   r = CH_N;
			PH_P3:   r = CH_E;
			default: r = CH_L;
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Input register
	// ---------------------------------------------------------------
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;
	logic       in_fire;

	// Result queue control
	logic [QPTR_W:0]   q_count_q;
	logic [QPTR_W-1:0] q_wptr_q;
	logic [QPTR_W-1:0] q_rptr_q;
	logic              half_q;
	res_entry_t        qmem [QDEPTH];

	// Accept only while the queue can still take the item in flight plus this one
	assign in_ch.ready = ((q_count_q + (QPTR_W+1)'(valid_s1)) < (QPTR_W+1)'(QDEPTH));
	assign in_fire     = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= in_ch.in_byte;
			eof_s1  <= in_ch.end_of_file;
		end
	end

	// ---------------------------------------------------------------
	// Scanner state
	// ---------------------------------------------------------------
	logic [1:0]       mode_q,  mode_n;
	logic             quote_q, quote_n;
	logic             esc_q,   esc_n;
	logic             sp_q,    sp_n;
	logic             skip_q,  skip_n;
	logic             atls_q,  atls_n;
	logic [CNT_W-1:0] stmt_q,  stmt_n;
	logic [CNT_W-1:0] dcnt_q,  dcnt_n;
	logic [3:0]       dph_q,   dph_n;
	logic [31:0]      dval_q,  dval_n;
	logic             dneg_q,  dneg_n;
	logic [31:0]      phys_q,  phys_n;
	logic [31:0]      logl_q,  logl_n;
	logic             ended_q, ended_n;

	// ---------------------------------------------------------------
	// Directive parser step for the registered byte
	// ---------------------------------------------------------------
	logic [3:0]  dph_adv;
	logic [31:0] dval_adv;
	logic        dneg_adv;
	logic [7:0]  digit;
	logic [35:0] acc;

	always_comb begin
		dph_adv  = dph_q;
		dval_adv = dval_q;
		dneg_adv = dneg_q;
		digit    = byte_s1 - CH_ZERO;
		// value * 10 + digit as two shifted adds
		acc = {1'b0, dval_q, 3'b000} + {3'b000, dval_q, 1'b0} + {28'd0, digit};
		case (dph_q)
			PH_P0: begin
				if (byte_s1 == CH_L) dph_adv = PH_P1;
				else                 dph_adv = is_ws(byte_s1) ? PH_SPACE : PH_INVALID;
			end
			PH_P1, PH_P2, PH_P3: begin
				dph_adv = (byte_s1 == line_char(dph_q)) ? dph_q + 4'd1 : PH_INVALID;
			end
			PH_AFTER: begin
				dph_adv = is_ws(byte_s1) ? PH_SPACE : PH_INVALID;
			end
			PH_SPACE, PH_SIGN: begin
				if (is_digit(byte_s1)) begin
					dval_adv = {24'd0, digit};
					dph_adv  = PH_DIGITS;
				end else if (dph_q == PH_SPACE && is_ws(byte_s1)) begin
					dph_adv = PH_SPACE;
				end else if (dph_q == PH_SPACE
						&& (byte_s1 == CH_PLUS || byte_s1 == CH_MINUS)) begin
					dneg_adv = (byte_s1 == CH_MINUS);
					dph_adv  = PH_SIGN;
				end else begin
					dph_adv = PH_INVALID;
				end
			end
			PH_DIGITS: begin
				if (is_digit(byte_s1)) begin
					// saturate the magnitude at 2^31
					dval_adv = (acc > {4'd0, VAL_CAP}) ? VAL_CAP : acc[31:0];
				end else begin
					dph_adv = (is_ws(byte_s1) || byte_s1 == CH_NUL) ? PH_VALID : PH_INVALID;
				end
			end
			PH_VALID: dph_adv = PH_VALID;
			default:  dph_adv = PH_INVALID;
		endcase
	end

	// Logical line set by a well-formed directive
	logic [31:0] dir_line;
	assign dir_line = dneg_q ? (32'd0 - dval_q) : (dval_q[31] ? LINE_MAX : dval_q);

	// ---------------------------------------------------------------
	// Main scanner step
	// ---------------------------------------------------------------
	logic       do_close;
	status_t    close_st;
	logic       clr_dir;
	logic       push;
	res_entry_t entry;
	logic [CNT_W:0] dir_total;
	logic       at_limit;

	assign dir_total = {1'b0, stmt_q} + {1'b0, dcnt_q};

	always_comb begin
		mode_n  = mode_q;
		quote_n = quote_q;
		esc_n   = esc_q;
		sp_n    = sp_q;
		skip_n  = skip_q;
		atls_n  = atls_q;
		stmt_n  = stmt_q;
		dcnt_n  = dcnt_q;
		dph_n   = dph_q;
		dval_n  = dval_q;
		dneg_n  = dneg_q;
		phys_n  = phys_q;
		logl_n  = logl_q;
		ended_n = ended_q;

		do_close = 1'b0;
		close_st = ST_OK;
		clr_dir  = 1'b0;
		push     = 1'b0;
		at_limit = 1'b0;

		// results carry the counters as they stand before this step
		entry.kind    = KIND_CHAR;
		entry.chr     = byte_s1;
		entry.status  = ST_OK;
		entry.phys    = phys_q;
		entry.logical = logl_q;
		entry.space   = 1'b0;

		if (valid_s1) begin
			if (ended_q) begin
				do_close = 1'b1;
				close_st = ST_CLEAN;
			end else if (eof_s1) begin
				ended_n  = 1'b1;
				do_close = 1'b1;
				close_st = (mode_q == MODE_STRING || stmt_q != '0) ? ST_UNEXP : ST_CLEAN;
			end else begin
				case (mode_q)
					MODE_DIR: begin
						at_limit = (dir_total >= {1'b0, STMT_LIMIT});
						if (at_limit) begin
							do_close = 1'b1;
							close_st = ST_LONG;
						end else if (byte_s1 == CH_NL) begin
							phys_n  = phys_q + 32'd1;
							logl_n  = (dph_q == PH_DIGITS || dph_q == PH_VALID)
								? dir_line : logl_q + 32'd1;
							mode_n  = MODE_NORMAL;
							clr_dir = 1'b1;
						end else begin
							dcnt_n = dcnt_q + CNT_W'(1);
							dph_n  = dph_adv;
							dval_n = dval_adv;
							dneg_n = dneg_adv;
						end
					end
					MODE_STRING: begin
						at_limit = (stmt_q >= STMT_LIMIT);
						if (at_limit) begin
							do_close = 1'b1;
							close_st = ST_LONG;
						end else if (byte_s1 == CH_NL) begin
							do_close = 1'b1;
							close_st = ST_NL_STR;
						end else begin
							stmt_n = stmt_q + CNT_W'(1);
							if (byte_s1 == CH_SPACE) begin
								// release any older held space, hold this one
								push      = sp_q;
								entry.chr = CH_SPACE;
								sp_n      = 1'b1;
							end else begin
								push        = 1'b1;
								entry.space = sp_q;
								sp_n        = 1'b0;
							end
							if (esc_q) begin
								esc_n = 1'b0;
							end else if (byte_s1 == CH_BSLASH) begin
								esc_n = 1'b1;
							end else if (byte_s1 == (quote_q ? CH_SQUOTE : CH_DQUOTE)) begin
								mode_n = MODE_NORMAL;
							end
						end
					end
					default: begin
						at_limit = (stmt_q >= STMT_LIMIT);
						if (at_limit) begin
							do_close = 1'b1;
							close_st = ST_LONG;
						end else if (atls_q && byte_s1 == CH_HASH) begin
							mode_n  = MODE_DIR;
							clr_dir = 1'b1;
						end else begin
							atls_n = (byte_s1 == CH_NL);
							if (byte_s1 == CH_NL) begin
								phys_n = phys_q + 32'd1;
								logl_n = logl_q + 32'd1;
							end
							if (is_ws(byte_s1)) begin
								// collapse a whitespace run into one held space
								if (!skip_q) begin
									stmt_n = stmt_q + CNT_W'(1);
									sp_n   = 1'b1;
									skip_n = 1'b1;
								end
							end else if (byte_s1 == CH_SEMI) begin
								do_close = 1'b1;
								close_st = ST_OK;
							end else begin
								skip_n      = 1'b0;
								push        = 1'b1;
								entry.space = sp_q;
								sp_n        = 1'b0;
								stmt_n      = stmt_q + CNT_W'(1);
								if (byte_s1 == CH_DQUOTE || byte_s1 == CH_SQUOTE) begin
									quote_n = (byte_s1 == CH_SQUOTE);
									esc_n   = 1'b0;
									mode_n  = MODE_STRING;
								end
							end
						end
					end
				endcase
			end
		end

		if (do_close) begin
			// end beat; a held space is dropped
			push         = 1'b1;
			entry.kind   = KIND_END;
			entry.chr    = 8'h00;
			entry.status = close_st;
			entry.space  = 1'b0;
			mode_n       = MODE_NORMAL;
			esc_n        = 1'b0;
			sp_n         = 1'b0;
			skip_n       = 1'b1;
			stmt_n       = '0;
			clr_dir      = 1'b1;
		end

		if (clr_dir) begin
			dcnt_n = '0;
			dph_n  = PH_P0;
			dval_n = '0;
			dneg_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NORMAL;
			quote_q <= 1'b0;
			esc_q   <= 1'b0;
			sp_q    <= 1'b0;
			skip_q  <= 1'b1;
			atls_q  <= 1'b1;
			stmt_q  <= '0;
			dcnt_q  <= '0;
			dph_q   <= PH_P0;
			dval_q  <= '0;
			dneg_q  <= 1'b0;
			phys_q  <= 32'd1;
			logl_q  <= 32'd1;
			ended_q <= 1'b0;
		end else begin
			mode_q  <= mode_n;
			quote_q <= quote_n;
			esc_q   <= esc_n;
			sp_q    <= sp_n;
			skip_q  <= skip_n;
			atls_q  <= atls_n;
			stmt_q  <= stmt_n;
			dcnt_q  <= dcnt_n;
			dph_q   <= dph_n;
			dval_q  <= dval_n;
			dneg_q  <= dneg_n;
			phys_q  <= phys_n;
			logl_q  <= logl_n;
			ended_q <= ended_n;
		end
	end

	// ---------------------------------------------------------------
	// Result queue: at most one entry per input item, a held space goes out first
	// ---------------------------------------------------------------
	res_entry_t head;
	logic       show_space;
	logic       out_fire;
	logic       pop;
	logic       wr;

	assign wr         = valid_s1 && push;
	assign head       = qmem[q_rptr_q];
	assign show_space = head.space && !half_q;
	assign out_fire   = out_ch.valid && out_ch.ready;
	assign pop        = out_fire && !show_space;

	always_ff @(posedge clk) begin
		if (wr) begin
			qmem[q_wptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_count_q <= '0;
			q_wptr_q  <= '0;
			q_rptr_q  <= '0;
			half_q    <= 1'b0;
		end else begin
			q_count_q <= q_count_q + (QPTR_W+1)'(wr) - (QPTR_W+1)'(pop);
			if (wr) begin
				q_wptr_q <= q_wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				q_rptr_q <= q_rptr_q + QPTR_W'(1);
				half_q   <= 1'b0;
			end else if (out_fire) begin
				// held space taken, the character follows
				half_q <= 1'b1;
			end
		end
	end

	assign out_ch.valid        = (q_count_q != '0);
	assign out_ch.out_kind     = show_space ? KIND_CHAR : head.kind;
	assign out_ch.out_char     = show_space ? CH_SPACE : head.chr;
	assign out_ch.end_status   = show_space ? ST_OK : head.status;
	assign out_ch.phys_line    = head.phys;
	assign out_ch.logical_line = $signed(head.logical);
	assign out_ch.out_last     = !show_space;

endmodule

`default_nettype wire

// ===== sv/cstrd_checker.sv =====
// Port-level checks for the statement reader, attached by a bind statement.
// Depends on cstrd_pkg and config_statement_reader.
`default_nettype none

module cstrd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic               out_kind,
	input logic [7:0]         out_char,
	input cstrd_pkg::status_t end_status,
	input logic               out_last
);
	import cstrd_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_char)
			&& $stable(end_status) && $stable(out_last))
		else $error("result beat changed while stalled");

	// an end beat is always the last of its item
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_END |-> out_last)
		else $error("end beat not marked last");

	// only a released held space can precede another result of the same item
	a_first_is_space: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> out_kind == KIND_CHAR && out_char == CH_SPACE)
		else $error("non-last beat is not a space");

	// a space that is not last is followed by a character, not an end beat
	a_space_then_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid && out_kind == KIND_CHAR)
		else $error("held space not followed by its character");

	// character beats carry a zero status
	a_char_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_CHAR |-> end_status == ST_OK)
		else $error("character beat with a status");

endmodule

bind config_statement_reader cstrd_checker u_cstrd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_kind   (out_ch.out_kind),
	.out_char   (out_ch.out_char),
	.end_status (out_ch.end_status),
	.out_last   (out_ch.out_last)
);

`default_nettype wire

// ===== verif/cstrd_result_checker.sv =====
// Result checker for the statement reader: follows every accepted source beat, predicts
// the statement results it causes and compares each result beat against the oldest one.
// Depends on cstrd_pkg, cstrd_in_if and cstrd_out_if.
`default_nettype none

module cstrd_result_checker (
	input  logic clk,
	input  logic arst_n,
	cstrd_in_if  in_ch,
	cstrd_out_if out_ch,
	output int   fail_count,
	output int   pending_results,
	output int   checked_results,
	output int   statement_ends
);
	import cstrd_pkg::*;

	typedef enum logic [1:0] {SCAN_NORMAL, SCAN_STRING, SCAN_DIRECTIVE} scan_mode_t;

	// Directive text progress: the first four track the "line" keyword
	typedef enum logic [3:0] {
		DIR_PREFIX, DIR_L, DIR_LI, DIR_LIN, DIR_AFTER_LINE,
		DIR_GAP, DIR_SIGN, DIR_DIGITS, DIR_VALID, DIR_BAD
	} dir_state_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  chr;
		status_t     status;
		logic [31:0] phys;
		logic [31:0] logical;
		logic        last;
	} stmt_result_t;

	localparam int          LEN_LIMIT   = MAX_STMT - 1;
	localparam logic [7:0]  CH_NL       = 8'h0A;
	localparam logic [7:0]  CH_HASH     = "#";
	localparam logic [7:0]  CH_SEMI     = ";";
	localparam logic [7:0]  CH_DQUOTE   = "\"";
	localparam logic [7:0]  CH_SQUOTE   = "'";
	localparam logic [7:0]  CH_BSLASH   = "\\";
	localparam logic [7:0]  CH_ZERO     = "0";
	localparam logic [7:0]  CH_NINE     = "9";
	localparam logic [7:0]  CH_PLUS     = "+";
	localparam logic [7:0]  CH_MINUS    = "-";
	localparam logic [31:0] DIR_CAP     = 32'h8000_0000;
	localparam logic [31:0] LOGICAL_MAX = 32'h7FFF_FFFF;

	scan_mode_t  mode;
	logic        single_quote;
	logic        escape_next;
	logic        held_space;
	logic        drop_ws;
	logic        line_start;
	logic        src_done;
	int          stmt_len;
	int          dir_len;
	dir_state_t  dir_state;
	logic [31:0] dir_num;
	logic        dir_minus;
	logic [31:0] phys_cnt;
	logic [31:0] logic_cnt;

	stmt_result_t expected_results[$];
	int mismatches;
	int result_beats;
	int end_beats;

	function automatic logic is_space_char(input logic [7:0] c);
		return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_digit_char(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	task automatic push_result(input logic kind, input logic [7:0] chr, input status_t st);
		stmt_result_t r;
		r.kind    = kind;
		r.chr     = chr;
		r.status  = st;
		r.phys    = phys_cnt;
		r.logical = logic_cnt;
		r.last    = 1'b0;
		expected_results.push_back(r);
	endtask

	task automatic clear_directive();
		dir_len   = 0;
		dir_state = DIR_PREFIX;
		dir_num   = '0;
		dir_minus = 1'b0;
	endtask

	task automatic close_statement(input status_t st);
		push_result(KIND_END, 8'h00, st);
		mode        = SCAN_NORMAL;
		escape_next = 1'b0;
		held_space  = 1'b0;
		drop_ws     = 1'b1;
		stmt_len    = 0;
		clear_directive();
	endtask

	task automatic release_held_space();
		if (held_space) begin
			push_result(KIND_CHAR, CH_SPACE, ST_OK);
			held_space = 1'b0;
		end
	endtask

	task automatic reset_reader();
		mode         = SCAN_NORMAL;
		single_quote = 1'b0;
		escape_next  = 1'b0;
		held_space   = 1'b0;
		drop_ws      = 1'b1;
		line_start   = 1'b1;
		stmt_len     = 0;
		clear_directive();
		phys_cnt     = 32'd1;
		logic_cnt    = 32'd1;
		src_done     = 1'b0;
	endtask

	task automatic advance_directive(input logic [7:0] c);
		logic [63:0] acc;
		case (dir_state)
			DIR_PREFIX: begin
				if (c == "l")
					dir_state = DIR_L;
				else
					dir_state = is_space_char(c) ? DIR_GAP : DIR_BAD;
			end
			DIR_L:          dir_state = (c == "i") ? DIR_LI : DIR_BAD;
			DIR_LI:         dir_state = (c == "n") ? DIR_LIN : DIR_BAD;
			DIR_LIN:        dir_state = (c == "e") ? DIR_AFTER_LINE : DIR_BAD;
			DIR_AFTER_LINE: dir_state = is_space_char(c) ? DIR_GAP : DIR_BAD;
			DIR_GAP, DIR_SIGN: begin
				if (is_digit_char(c)) begin
					dir_num   = {24'd0, c - CH_ZERO};
					dir_state = DIR_DIGITS;
				end else if (dir_state == DIR_GAP && is_space_char(c)) begin
					dir_state = DIR_GAP;
				end else if (dir_state == DIR_GAP && (c == CH_PLUS || c == CH_MINUS)) begin
					dir_minus = (c == CH_MINUS);
					dir_state = DIR_SIGN;
				end else begin
					dir_state = DIR_BAD;
				end
			end
			DIR_DIGITS: begin
				if (is_digit_char(c)) begin
					acc     = {32'd0, dir_num} * 64'd10 + {56'd0, c - CH_ZERO};
					dir_num = (acc > {32'd0, DIR_CAP}) ? DIR_CAP : acc[31:0];
				end else begin
					dir_state = (is_space_char(c) || c == 8'h00) ? DIR_VALID : DIR_BAD;
				end
			end
			DIR_VALID: ;
			default:   dir_state = DIR_BAD;
		endcase
	endtask

	task automatic predict_reader_results(input logic [7:0] c, input logic eof);
		int first;
		stmt_result_t r;
		first = expected_results.size();
		if (src_done) begin
			close_statement(ST_CLEAN);
		end else if (eof) begin
			src_done = 1'b1;
			close_statement((mode == SCAN_STRING || stmt_len != 0) ? ST_UNEXP : ST_CLEAN);
		end else if (mode == SCAN_DIRECTIVE) begin
			if (stmt_len + dir_len >= LEN_LIMIT) begin
				close_statement(ST_LONG);
			end else if (c == CH_NL) begin
				phys_cnt  = phys_cnt + 32'd1;
				logic_cnt = logic_cnt + 32'd1;
				if (dir_state == DIR_DIGITS || dir_state == DIR_VALID) begin
					if (dir_minus)
						logic_cnt = 32'd0 - dir_num;
					else
						logic_cnt = (dir_num > LOGICAL_MAX) ? LOGICAL_MAX : dir_num;
				end
				mode = SCAN_NORMAL;
				clear_directive();
			end else begin
				dir_len++;
				advance_directive(c);
			end
		end else if (mode == SCAN_STRING) begin
			if (stmt_len >= LEN_LIMIT) begin
				close_statement(ST_LONG);
			end else if (c == CH_NL) begin
				close_statement(ST_NL_STR);
			end else begin
				stmt_len++;
				release_held_space();
				if (c == CH_SPACE)
					held_space = 1'b1;
				else
					push_result(KIND_CHAR, c, ST_OK);
				if (escape_next)
					escape_next = 1'b0;
				else if (c == CH_BSLASH)
					escape_next = 1'b1;
				else if (c == (single_quote ? CH_SQUOTE : CH_DQUOTE))
					mode = SCAN_NORMAL;
			end
		end else begin
			if (stmt_len >= LEN_LIMIT) begin
				close_statement(ST_LONG);
			end else if (line_start && c == CH_HASH) begin
				mode = SCAN_DIRECTIVE;
				clear_directive();
			end else begin
				line_start = (c == CH_NL);
				if (c == CH_NL) begin
					phys_cnt  = phys_cnt + 32'd1;
					logic_cnt = logic_cnt + 32'd1;
				end
				if (is_space_char(c)) begin
					if (!drop_ws) begin
						stmt_len++;
						held_space = 1'b1;
						drop_ws    = 1'b1;
					end
				end else if (c == CH_SEMI) begin
					drop_ws = 1'b0;
					close_statement(ST_OK);
				end else begin
					drop_ws = 1'b0;
					release_held_space();
					push_result(KIND_CHAR, c, ST_OK);
					stmt_len++;
					if (c == CH_DQUOTE || c == CH_SQUOTE) begin
						single_quote = (c == CH_SQUOTE);
						escape_next  = 1'b0;
						mode         = SCAN_STRING;
					end
				end
			end
		end
		// Mark the final result of this beat
		if (expected_results.size() > first) begin
			r = expected_results.pop_back();
			r.last = 1'b1;
			expected_results.push_back(r);
		end
	endtask

	task automatic check_result();
		stmt_result_t want;
		stmt_result_t got;
		got.kind    = out_ch.out_kind;
		got.chr     = out_ch.out_char;
		got.status  = out_ch.end_status;
		got.phys    = out_ch.phys_line;
		got.logical = out_ch.logical_line;
		got.last    = out_ch.out_last;
		result_beats++;
		if (got.kind == KIND_END)
			end_beats++;
		if (expected_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("Unexpected result beat %0d: kind=%0d char=%02h status=%0d",
					result_beats, got.kind, got.chr, got.status);
				$display("  phys=%0d logical=%0d last=%0d",
					got.phys, $signed(got.logical), got.last);
			end
		end else begin
			want = expected_results.pop_front();
			if (got.kind !== want.kind || got.chr !== want.chr || got.status !== want.status ||
				got.phys !== want.phys || got.logical !== want.logical ||
				got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("Result beat %0d mismatch", result_beats);
					$display("  expected kind=%0d char=%02h status=%0d phys=%0d logical=%0d last=%0d",
						want.kind, want.chr, want.status, want.phys,
						$signed(want.logical), want.last);
					$display("  actual   kind=%0d char=%02h status=%0d phys=%0d logical=%0d last=%0d",
						got.kind, got.chr, got.status, got.phys,
						$signed(got.logical), got.last);
				end
			end
		end
	endtask

	initial begin
		reset_reader();
		mismatches      = 0;
		result_beats    = 0;
		end_beats       = 0;
		fail_count      = 0;
		pending_results = 0;
		checked_results = 0;
		statement_ends  = 0;
	end

	// No result shows in the cycle its source beat is taken, so take the result side first
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_reader();
			expected_results.delete();
		end else begin
			if (out_ch.valid && out_ch.ready)
				check_result();
			if (in_ch.valid && in_ch.ready)
				predict_reader_results(in_ch.in_byte, in_ch.end_of_file);
		end
		fail_count      <= mismatches;
		pending_results <= expected_results.size();
		checked_results <= result_beats;
		statement_ends  <= end_beats;
	end

endmodule

`default_nettype wire

// ===== verif/tb_config_statement_reader.sv =====
// Top level of the statement reader testbench: clock, reset, source stimulus, result stalls.
// Depends on cstrd_pkg, cstrd_in_if, cstrd_out_if, config_statement_reader and
// cstrd_result_checker, which does all prediction and comparison.
`default_nettype none

module tb_config_statement_reader;
	import cstrd_pkg::*;

	// The slowest correct run, at most two results per beat under two-thirds gaps and
	// stalls, fits in this limit many times over.
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 1650;

	localparam logic [7:0] NL     = 8'h0A;
	localparam logic [7:0] HASH   = "#";
	localparam logic [7:0] DQ     = "\"";
	localparam logic [7:0] SQ     = "'";
	localparam logic [7:0] BSLASH = "\\";

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int items_sent    = 0;
	int cycle_count   = 0;

	int fail_count;
	int pending_results;
	int checked_results;
	int statement_ends;

	cstrd_in_if  in_ch ();
	cstrd_out_if out_ch ();

	config_statement_reader dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	cstrd_result_checker result_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_ch           (in_ch),
		.out_ch          (out_ch),
		.fail_count      (fail_count),
		.pending_results (pending_results),
		.checked_results (checked_results),
		.statement_ends  (statement_ends)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Hard stop: a hung handshake or lost result ends here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding",
				cycle_count, pending_results);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Result side: drop ready at random according to the current stall rate
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			out_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Offer one beat, with random idle cycles ahead of it, and hold it until taken.
	// Valid stays high across back-to-back beats, so it never gets two updates in a step.
	task automatic send_item(input logic [7:0] b, input logic eof);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.in_byte     <= b;
		in_ch.end_of_file <= eof;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b0);
	endtask

	// Whitespace, mostly spaces and tabs, now and then a line break
	function automatic logic [7:0] pick_ws();
		case ($urandom_range(7))
			0, 1, 2, 3: return CH_SPACE;
			4:          return 8'h09;
			5:          return NL;
			6:          return 8'h0D;
			default:    return 8'($urandom_range(11, 12));
		endcase
	endfunction

	// Gap inside a directive: a space, or a byte from 9 to 13, which may be a newline
	function automatic logic [7:0] pick_dir_gap();
		return $urandom_range(2) == 0 ? 8'($urandom_range(9, 13)) : CH_SPACE;
	endfunction

	// Token text: mostly printable, sometimes any byte at all (control, high, quotes, ';')
	function automatic logic [7:0] pick_token_char();
		logic [7:0] c;
		if ($urandom_range(4) == 0)
			return 8'($urandom_range(255));
		c = 8'($urandom_range(33, 126));
		if (c == ";" || c == DQ || c == SQ)
			c = "x";
		return c;
	endfunction

	// Quoted text with held spaces, escapes and stray quotes; now and then broken by a
	// newline or left open so that the next chunk lands inside the string
	task automatic send_quoted();
		logic [7:0] q;
		int tail;
		q = $urandom_range(1) ? SQ : DQ;
		send_item(q, 1'b0);
		repeat ($urandom_range(0, 8)) begin
			case ($urandom_range(5))
				0: send_item(CH_SPACE, 1'b0);
				1: begin
					send_item(BSLASH, 1'b0);
					send_item($urandom_range(1) ? q : pick_token_char(), 1'b0);
				end
				2:       send_item($urandom_range(1) ? DQ : SQ, 1'b0);
				default: send_item(pick_token_char(), 1'b0);
			endcase
		end
		tail = $urandom_range(19);
		if (tail < 17)
			send_item(q, 1'b0);
		else if (tail < 19)
			send_item(NL, 1'b0);
	endtask

	// Words and strings split by whitespace runs, closed by ';' in most cases
	task automatic send_statement();
		if ($urandom_range(2) == 0)
			send_item(pick_ws(), 1'b0);
		repeat ($urandom_range(1, 5)) begin
			if ($urandom_range(3) == 0)
				send_quoted();
			else
				repeat ($urandom_range(1, 6)) send_item(pick_token_char(), 1'b0);
			repeat ($urandom_range(0, 2)) send_item(pick_ws(), 1'b0);
		end
		if ($urandom_range(19) < 18)
			send_text(";");
	endtask

	// Line number with optional sign; the fixed ones are zero or lie on or past the saturation edges
	task automatic send_number();
		case ($urandom_range(5))
			0:       send_text("+");
			1:       send_text("-");
			default: ;
		endcase
		case ($urandom_range(7))
			0:       send_text("2147483647");
			1:       send_text("2147483648");
			2:       send_text("4294967295");
			3:       send_text("99999999999");
			4:       send_text("0");
			5:       send_text($sformatf("%0d", $urandom()));
			default: send_text($sformatf("%0d", $urandom_range(1, 9999)));
		endcase
	endtask

	// A directive line: well-formed line settings most of the time, then malformed ones
	task automatic send_directive();
		send_item(NL, 1'b0);
		send_item(HASH, 1'b0);
		case ($urandom_range(9))
			0, 1, 2, 3: begin
				send_text("line");
				repeat ($urandom_range(1, 2)) send_item(pick_dir_gap(), 1'b0);
				send_number();
			end
			4, 5: begin
				repeat ($urandom_range(1, 2)) send_item(pick_dir_gap(), 1'b0);
				send_number();
			end
			6: begin
				case ($urandom_range(3))
					0:       send_text("lin");
					1:       send_text("linex 4");
					2:       send_text("line5");
					default: send_text("lime 3");
				endcase
			end
			7: begin
				if ($urandom_range(1))
					send_text(" +");
				else
					send_text(" -x");
			end
			8: begin
				send_text("line ");
				send_number();
				send_item(pick_token_char(), 1'b0);
			end
			default: repeat ($urandom_range(1, 6)) send_item(8'($urandom_range(255)), 1'b0);
		endcase
		// Trailing text after the number, behind whitespace or a zero byte
		case ($urandom_range(3))
			0: begin
				send_item(CH_SPACE, 1'b0);
				repeat ($urandom_range(1, 4)) send_item(pick_token_char(), 1'b0);
			end
			1: begin
				send_item(8'h00, 1'b0);
				repeat ($urandom_range(1, 4)) send_item(pick_token_char(), 1'b0);
			end
			default: ;
		endcase
		send_item(NL, 1'b0);
	endtask

	// Run near or past the length bound, either as plain statement text (which may open a string
	// near the end) or as one overlong directive line
	task automatic send_long(input logic in_directive);
		int n;
		int quote_at;
		n        = $urandom_range(MAX_STMT - 10, MAX_STMT + 40);
		quote_at = $urandom_range(1) ? $urandom_range(MAX_STMT - 60, MAX_STMT - 20) : -1;
		if (in_directive)
			send_text("ab\n#line 1 ");
		for (int i = 0; i < n; i++) begin
			if (!in_directive && i == quote_at)
				send_item(DQ, 1'b0);
			else if ($urandom_range(9) == 0)
				send_item(CH_SPACE, 1'b0);
			else
				send_item(8'($urandom_range(97, 122)), 1'b0);
		end
		if (in_directive)
			send_text("\n");
		else
			send_text(";");
	endtask

	initial begin
		int pick;
		in_ch.valid       = 1'b0;
		in_ch.in_byte     = 8'h00;
		in_ch.end_of_file = 1'b0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: leading and trailing space drop, whitespace collapse, a quoted span
		// with an escaped quote and a held space before a character, newline inside a
		// string, extreme byte values, then "#line" and "# -N" settings
		send_text(" x \t;");
		send_text("'\\' b\n");
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b0);
		send_text(";\n");
		send_text("#line 9\n# -5\n");

		// Random part in four idling phases
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 66;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 66;
				end
				default: begin
					send_idle_pct = 11;
					stall_pct     = 11;
				end
			endcase
			if (phase == 1 || phase == 3)
				send_long(phase == 3);
			while (items_sent < (phase + 1) * RANDOM_ITEMS / 4) begin
				pick = $urandom_range(99);
				if (pick < 55)
					send_statement();
				else if (pick < 80)
					send_directive();
				else
					repeat ($urandom_range(1, 8)) send_item(8'($urandom_range(255)), 1'b0);
			end
		end

		// End of file from a random context, then beats that arrive after it
		case ($urandom_range(3))
			0:       send_text("tail");
			1:       send_text("\"open str");
			2:       send_text("\n#line 42");
			default: send_text(";");
		endcase
		send_item(8'($urandom_range(255)), 1'b1);
		repeat (6) send_item(8'($urandom_range(255)), 1'($urandom_range(1)));
		in_ch.valid <= 1'b0;

		// Let the checker see the last beat, drain, then allow for stray results
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d source beats over four idling phases, ending at end of file.",
			items_sent);
		$display("Checked %0d result beats, %0d of them statement ends.",
			checked_results, statement_ends);
		if (fail_count == 0 && pending_results == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
